>>> src/cgtc_pkg.sv
// Package with payload types, constants and reciprocal tables for the calendar and GPS converter.
package cgtc_pkg;

  typedef struct packed {
    logic        command;
    logic [11:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [15:0] milli_in;
    logic [14:0] week_in;
    logic [29:0] week_milli_in;
  } cgtc_in_t;

  typedef struct packed {
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [15:0] milli_out;
    logic [14:0] week_out;
    logic [29:0] week_milli_out;
    logic [17:0] mjd_day;
    logic [26:0] day_milli;
    logic        before_epoch;
  } cgtc_out_t;

  localparam logic CMD_CAL_TO_GPS = 1'b0;
  localparam logic CMD_GPS_TO_CAL = 1'b1;

  localparam int unsigned MS_PER_DAY    = 86400000;
  localparam int unsigned MS_PER_HOUR   = 3600000;
  localparam int unsigned MS_PER_MIN    = 60000;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned GPS_EPOCH_MJD = 44244;
  localparam int unsigned MJD_OFFSET    = 679019;
  localparam int unsigned EPOCH_SUM     = MJD_OFFSET + GPS_EPOCH_MJD;
  localparam int unsigned JD_BIAS       = 2400001 + 1537;
  localparam int unsigned JD_YEAR_NUM   = 1461;
  localparam int unsigned CENTURY_DAYS  = 36525;
  localparam int unsigned YEAR_OFS_X100 = 12210;
  localparam int unsigned YEAR_BIAS     = 4715;
  localparam int unsigned MONTH_NUM     = 306001;
  localparam int unsigned MONTH_DEN     = 10000;

  localparam int DAY_SHIFT  = 57;
  localparam int WEEK_SHIFT = 23;
  localparam int HOUR_SHIFT = 49;
  localparam int YEAR_SHIFT = 45;
  localparam int MIN_SHIFT  = 38;
  localparam int MON_SHIFT  = 30;

  localparam logic [30:0] DAY_RECIP =
    31'(((64'd1 << DAY_SHIFT) + 64'(MS_PER_DAY) - 64'd1) / 64'(MS_PER_DAY));
  localparam logic [20:0] WEEK_RECIP =
    21'(((64'd1 << WEEK_SHIFT) + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK));
  localparam logic [27:0] HOUR_RECIP =
    28'(((64'd1 << HOUR_SHIFT) + 64'(MS_PER_HOUR) - 64'd1) / 64'(MS_PER_HOUR));
  localparam logic [29:0] YEAR_RECIP =
    30'(((64'd1 << YEAR_SHIFT) + 64'(CENTURY_DAYS) - 64'd1) / 64'(CENTURY_DAYS));
  localparam logic [22:0] MIN_RECIP =
    23'(((64'd1 << MIN_SHIFT) + 64'(MS_PER_MIN) - 64'd1) / 64'(MS_PER_MIN));
  localparam logic [25:0] MON_RECIP =
    26'((64'(MONTH_DEN) * (64'd1 << MON_SHIFT) + 64'(MONTH_NUM) - 64'd1) / 64'(MONTH_NUM));

  // Whole days in i months of 30.6001 days, for i from 0 to 16.
  localparam logic [8:0] MONTH_OFS [17] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214, 9'd244,
    9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459, 9'd489
  };

endpackage

>>> src/calendar_gps_time_converter_unit.sv
// Top level of the pipelined converter between civil date and time, MJD and GPS time.
// Each transfer carries one conversion: command 0 turns a civil date and time into the
// MJD, millisecond of day, GPS week and millisecond of week, and command 1 turns a GPS
// week and millisecond of week into the civil date and time and the MJD. The datapath
// is seven register stages deep, each holding at most one level of constant
// multiplication, and one conversion can be taken every cycle while the output does
// not stall. Every stage holds its own valid bit and fills bubbles while the output
// waits.
// Civil dates before 1980-01-06 give all-zero fields with before_epoch set.
module calendar_gps_time_converter_unit
  import cgtc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cgtc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output cgtc_out_t out_data
);

  typedef struct packed {
    logic        cmd;
    logic [26:0] ms;
    logic [20:0] a;
    logic [8:0]  bm;
    logic [4:0]  d;
    logic        ylow;
    logic [17:0] wk7;
    logic [3:0]  qd;
    logic [29:0] wm;
  } s1_t;

  typedef struct packed {
    logic        cmd;
    logic        pre_epoch;
    logic [19:0] wd;
    logic [26:0] dms0;
    logic [17:0] mjd0;
    logic [18:0] mjd1;
    logic [26:0] dms1;
  } s2_t;

  typedef struct packed {
    logic        cmd;
    logic        pre_epoch;
    logic [16:0] wq;
    logic [19:0] wd;
    logic [26:0] dms0;
    logic [17:0] mjd0;
    logic [17:0] mjd1;
    logic [21:0] b;
    logic [28:0] n;
    logic [4:0]  hour;
    logic [26:0] dms1;
  } s3_t;

  typedef struct packed {
    logic        cmd;
    cgtc_out_t   res;
    logic [12:0] c;
    logic [21:0] b;
    logic [21:0] rem;
  } s4_t;

  typedef struct packed {
    logic        cmd;
    cgtc_out_t   res;
    logic [12:0] c;
    logic [8:0]  t;
    logic [21:0] rem;
  } s5_t;

  typedef struct packed {
    logic        cmd;
    cgtc_out_t   res;
    logic [12:0] c;
    logic [8:0]  t;
    logic [3:0]  e;
  } s6_t;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  s6_t s6_r, s6_nxt;
  cgtc_out_t out_r, out_nxt;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv_out;

  assign adv_out  = !out_valid_r || out_ready;
  assign adv6     = !v6_r || adv_out;
  assign adv5     = !v5_r || adv6;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Stage 1: time of day in milliseconds, year and month terms, GPS day count.
  logic        mon_lo;
  logic [11:0] y_adj;
  logic [3:0]  m_adj;
  logic [22:0] a_prod;
  logic [60:0] day_prod;

  always_comb begin
    mon_lo   = in_data.month_in <= 4'd2;
    y_adj    = mon_lo ? in_data.year_in - 12'd1 : in_data.year_in;
    m_adj    = mon_lo ? in_data.month_in + 4'd12 : in_data.month_in;
    a_prod   = 23'(y_adj) * 23'(JD_YEAR_NUM);
    day_prod = 61'(in_data.week_milli_in) * 61'(DAY_RECIP);
    s1_nxt.cmd  = in_data.command;
    s1_nxt.ms   = 27'(in_data.hour_in) * 27'(MS_PER_HOUR)
                + 27'(in_data.minute_in) * 27'(MS_PER_MIN)
                + 27'(in_data.milli_in);
    s1_nxt.a    = a_prod[22:2];
    s1_nxt.bm   = MONTH_OFS[5'(m_adj) + 5'd1];
    s1_nxt.d    = in_data.day_in;
    s1_nxt.ylow = mon_lo && (in_data.year_in == 12'd0);
    s1_nxt.wk7  = 18'(in_data.week_in) * 18'(DAYS_PER_WEEK);
    s1_nxt.qd   = day_prod[DAY_SHIFT+3:DAY_SHIFT];
    s1_nxt.wm   = in_data.week_milli_in;
  end

  // Stage 2: day carry, MJD sum and epoch check; GPS side MJD and millisecond of day.
  logic        carry;
  logic [20:0] day_sum;

  always_comb begin
    carry   = s1_r.ms >= 27'(MS_PER_DAY);
    day_sum = s1_r.a + 21'(s1_r.bm) + 21'(s1_r.d) + 21'(carry);
    s2_nxt.cmd       = s1_r.cmd;
    s2_nxt.pre_epoch = s1_r.ylow || (day_sum < 21'(EPOCH_SUM));
    s2_nxt.wd        = 20'(day_sum - 21'(EPOCH_SUM));
    s2_nxt.dms0      = carry ? s1_r.ms - 27'(MS_PER_DAY) : s1_r.ms;
    s2_nxt.mjd0      = 18'(day_sum - 21'(MJD_OFFSET));
    s2_nxt.mjd1      = 19'(GPS_EPOCH_MJD) + 19'(s1_r.wk7) + 19'(s1_r.qd);
    s2_nxt.dms1      = 27'(s1_r.wm - 30'(s1_r.qd) * 30'(MS_PER_DAY));
  end

  // Stage 3: week quotient, Julian day terms and hour of day.
  logic [40:0] week_prod;
  logic [54:0] hour_prod;
  logic [21:0] b_v;

  always_comb begin
    week_prod = 41'(s2_r.wd) * 41'(WEEK_RECIP);
    hour_prod = 55'(s2_r.dms1) * 55'(HOUR_RECIP);
    b_v       = 22'(s2_r.mjd1) + 22'(JD_BIAS);
    s3_nxt.cmd       = s2_r.cmd;
    s3_nxt.pre_epoch = s2_r.pre_epoch;
    s3_nxt.wq        = week_prod[WEEK_SHIFT+16:WEEK_SHIFT];
    s3_nxt.wd        = s2_r.wd;
    s3_nxt.dms0      = s2_r.dms0;
    s3_nxt.mjd0      = s2_r.mjd0;
    s3_nxt.mjd1      = s2_r.mjd1[17:0];
    s3_nxt.b         = b_v;
    s3_nxt.n         = 29'(b_v) * 29'd100 - 29'(YEAR_OFS_X100);
    s3_nxt.hour      = hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
    s3_nxt.dms1      = s2_r.dms1;
  end

  // Stage 4: GPS result complete; Julian year count and remainder within the hour.
  logic [58:0] year_prod;
  logic [2:0]  wk_rem;

  always_comb begin
    year_prod = 59'(s3_r.n) * 59'(YEAR_RECIP);
    wk_rem    = 3'(s3_r.wd - 20'(s3_r.wq) * 20'(DAYS_PER_WEEK));
    s4_nxt.cmd = s3_r.cmd;
    s4_nxt.res = '0;
    if (s3_r.cmd == CMD_GPS_TO_CAL) begin
      s4_nxt.res.mjd_day   = s3_r.mjd1;
      s4_nxt.res.day_milli = s3_r.dms1;
      s4_nxt.res.hour_out  = s3_r.hour;
    end else if (s3_r.pre_epoch) begin
      s4_nxt.res.before_epoch = 1'b1;
    end else begin
      s4_nxt.res.week_out       = s3_r.wq[14:0];
      s4_nxt.res.week_milli_out = 30'(wk_rem) * 30'(MS_PER_DAY) + 30'(s3_r.dms0);
      s4_nxt.res.mjd_day        = s3_r.mjd0;
      s4_nxt.res.day_milli      = s3_r.dms0;
    end
    s4_nxt.c   = year_prod[YEAR_SHIFT+12:YEAR_SHIFT];
    s4_nxt.b   = s3_r.b;
    s4_nxt.rem = 22'(s3_r.dms1 - 27'(s3_r.hour) * 27'(MS_PER_HOUR));
  end

  // Stage 5: day within the Julian year and minute of hour.
  logic [23:0] dd_prod;
  logic [44:0] min_prod;

  always_comb begin
    dd_prod  = 24'(s4_r.c) * 24'(JD_YEAR_NUM);
    min_prod = 45'(s4_r.rem) * 45'(MIN_RECIP);
    s5_nxt.cmd = s4_r.cmd;
    s5_nxt.res = s4_r.res;
    if (s4_r.cmd == CMD_GPS_TO_CAL) begin
      s5_nxt.res.minute_out = min_prod[MIN_SHIFT+5:MIN_SHIFT];
    end
    s5_nxt.c   = s4_r.c;
    s5_nxt.t   = 9'(s4_r.b - dd_prod[23:2]);
    s5_nxt.rem = s4_r.rem;
  end

  // Stage 6: month index and millisecond of minute.
  logic [34:0] mon_prod;

  always_comb begin
    mon_prod = 35'(s5_r.t) * 35'(MON_RECIP);
    s6_nxt.cmd = s5_r.cmd;
    s6_nxt.res = s5_r.res;
    if (s5_r.cmd == CMD_GPS_TO_CAL) begin
      s6_nxt.res.milli_out = 16'(s5_r.rem - 22'(s5_r.res.minute_out) * 22'(MS_PER_MIN));
    end
    s6_nxt.c = s5_r.c;
    s6_nxt.t = s5_r.t;
    s6_nxt.e = mon_prod[MON_SHIFT+3:MON_SHIFT];
  end

  // Stage 7: civil year, month and day.
  logic [3:0] mon_v;

  always_comb begin
    mon_v   = (s6_r.e >= 4'd14) ? s6_r.e - 4'd13 : s6_r.e - 4'd1;
    out_nxt = s6_r.res;
    if (s6_r.cmd == CMD_GPS_TO_CAL) begin
      out_nxt.month_out = mon_v;
      out_nxt.day_out   = 5'(s6_r.t - MONTH_OFS[5'(s6_r.e)]);
      out_nxt.year_out  = 12'(13'(s6_r.c) - 13'(YEAR_BIAS)
                        - ((mon_v >= 4'd3) ? 13'd1 : 13'd0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
      if (adv4) begin
        v4_r <= v3_r;
      end
      if (adv5) begin
        v5_r <= v4_r;
      end
      if (adv6) begin
        v6_r <= v5_r;
      end
      if (adv_out) begin
        out_valid_r <= v6_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_r <= s1_nxt;
    end
    if (adv2) begin
      s2_r <= s2_nxt;
    end
    if (adv3) begin
      s3_r <= s3_nxt;
    end
    if (adv4) begin
      s4_r <= s4_nxt;
    end
    if (adv5) begin
      s5_r <= s5_nxt;
    end
    if (adv6) begin
      s6_r <= s6_nxt;
    end
    if (adv_out) begin
      out_r <= out_nxt;
    end
  end

endmodule
